>>> design/u2hk_pkg.sv
package u2hk_pkg;

    localparam logic [1:0] FUNC_TEXT   = 2'd0;
    localparam logic [1:0] FUNC_DIRECT = 2'd1;
    localparam logic [1:0] FUNC_DEAD   = 2'd2;

    localparam logic [1:0] ACT_PRESS   = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_TAP     = 2'd2;

    localparam logic [7:0] KEY_LSHIFT = 8'h81;
    localparam logic [7:0] KEY_LALT   = 8'h82;
    localparam logic [7:0] KEY_RALT   = 8'h86;
    localparam logic [7:0] TAP_OFFSET = 8'd136;

    localparam logic [15:0] FLAG_ALT = 16'h0400;

    localparam logic [2:0] REG_DIRECT_USED = 3'd0;
    localparam logic [2:0] REG_DEAD_USED   = 3'd1;

    typedef enum logic [2:0] {
        PH_IDLE, PH_2OF2, PH_2OF3, PH_3OF3, PH_2OF4, PH_3OF4, PH_4OF4
    } t_phase;

    // key emitter request: tap keycode with its modifier presses around it
    typedef struct packed {
        logic        start;
        logic [15:0] kc;
        logic        final_one;
    } t_tap_req;

    typedef struct packed {
        logic busy;
    } t_tap_stat;

    typedef enum logic [1:0] {
        TP_PRE, TP_TAP, TP_POST
    } t_tap_state;

    typedef enum logic [4:0] {
        S_IDLE, S_D_RD, S_D_CHK, S_K_RD, S_K_CHK, S_B_RD, S_B_CHK,
        S_TAP_DEAD, S_WAIT_DEAD, S_TAP_BASE, S_WAIT_BASE,
        S_TAP_DIRECT, S_WAIT_DIRECT,
        S_ALT_PRESS, S_H_RD, S_H_CHK, S_H_TAP, S_H_WAIT, S_ALT_REL
    } t_seq_state;

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        hex_char = (d < 4'd10) ? (8'h30 + {4'd0, d}) : (8'h57 + {4'd0, d});
    endfunction

endpackage

>>> design/u2hk_tap.sv
module u2hk_tap (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  u2hk_pkg::t_tap_req   i_req,
    output u2hk_pkg::t_tap_stat  o_stat,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [1:0]           o_action,
    output logic [7:0]           o_key,
    output logic                 o_last
);
    import u2hk_pkg::*;

    t_tap_state  r_state, n_state;
    logic        r_busy, n_busy;
    logic [1:0]  r_mod, n_mod;
    logic [15:0] r_kc;
    logic        r_final;

    logic        w_has;
    logic [7:0]  w_mkey;
    logic        w_any_post;

    always_comb begin
        unique case (r_mod)
            2'd0:    begin w_has = r_kc[8];  w_mkey = KEY_LSHIFT; end
            2'd1:    begin w_has = r_kc[9];  w_mkey = KEY_RALT;   end
            default: begin w_has = r_kc[10]; w_mkey = KEY_LALT;   end
        endcase
    end

    // is any modifier left above r_mod (used to mark the last release)
    always_comb begin
        unique case (r_mod)
            2'd0:    w_any_post = |r_kc[10:9];
            2'd1:    w_any_post = r_kc[10];
            default: w_any_post = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TP_PRE;
            r_busy  <= 1'b0;
            r_mod   <= 2'd0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
            r_mod   <= n_mod;
        end
        if (i_req.start) begin
            r_kc    <= i_req.kc;
            r_final <= i_req.final_one;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_busy   = r_busy;
        n_mod    = r_mod;
        o_valid  = 1'b0;
        o_action = ACT_TAP;
        o_key    = w_mkey;
        o_last   = 1'b0;
        if (i_req.start) begin
            n_busy  = 1'b1;
            n_state = TP_PRE;
            n_mod   = 2'd0;
        end else if (r_busy) begin
            unique case (r_state)
                TP_PRE: begin
                    if (!w_has || r_mod == 2'd3) begin
                        if (r_mod == 2'd2 || r_mod == 2'd3) begin
                            n_state = TP_TAP;
                        end else begin
                            n_mod = r_mod + 2'd1;
                        end
                    end else begin
                        o_valid  = 1'b1;
                        o_action = ACT_PRESS;
                        if (i_ready) begin
                            if (r_mod == 2'd2) n_state = TP_TAP;
                            else n_mod = r_mod + 2'd1;
                        end
                    end
                end
                TP_TAP: begin
                    o_valid  = 1'b1;
                    o_action = ACT_TAP;
                    o_key    = r_kc[7:0] + TAP_OFFSET;
                    o_last   = r_final && !(|r_kc[10:8]);
                    if (i_ready) begin
                        n_state = TP_POST;
                        n_mod   = 2'd0;
                    end
                end
                default: begin
                    if (!w_has || r_mod == 2'd3) begin
                        if (r_mod == 2'd2 || r_mod == 2'd3) n_busy = 1'b0;
                        else n_mod = r_mod + 2'd1;
                    end else begin
                        o_valid  = 1'b1;
                        o_action = ACT_RELEASE;
                        o_last   = r_final && !w_any_post;
                        if (i_ready) begin
                            if (r_mod == 2'd2) n_busy = 1'b0;
                            else n_mod = r_mod + 2'd1;
                        end
                    end
                end
            endcase
        end
    end

    assign o_stat.busy = r_busy;
endmodule

>>> design/u2hk_seq.sv
module u2hk_seq #(
    parameter int DIRECT_DEPTH  = 256,
    parameter int DEADKEY_DEPTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [1:0]          i_func,
    input  logic [7:0]          i_text_byte,
    input  logic [7:0]          i_entry_index,
    input  logic [15:0]         i_entry_codepoint,
    input  logic [15:0]         i_entry_keycode,
    input  logic [15:0]         i_entry_base,
    input  logic [8:0]          i_direct_used,
    input  logic [6:0]          i_dead_used,
    output logic                o_busy,
    output u2hk_pkg::t_tap_req  o_tap_req,
    input  u2hk_pkg::t_tap_stat i_tap_stat,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [1:0]          o_action,
    output logic [7:0]          o_key,
    output logic                o_last
);
    import u2hk_pkg::*;

    localparam int DAW = (DIRECT_DEPTH > 1) ? $clog2(DIRECT_DEPTH) : 1;
    localparam int KAW = (DEADKEY_DEPTH > 1) ? $clog2(DEADKEY_DEPTH) : 1;
    localparam int DCW = $clog2(DIRECT_DEPTH + 1);
    localparam int KCW = $clog2(DEADKEY_DEPTH + 1);
    // compare width covering any entry count and any depth below 65536
    localparam int XW  = 16;

    logic [31:0] r_dmem [DIRECT_DEPTH];
    logic [47:0] r_kmem [DEADKEY_DEPTH];
    logic [31:0] r_drd;
    logic [47:0] r_krd;

    t_seq_state  r_state, n_state;
    t_phase      r_phase, n_phase;
    logic [20:0] r_partial, n_partial;
    logic [20:0] r_cp, n_cp;
    logic [DCW-1:0] r_di, n_di;
    logic [KCW-1:0] r_ki, n_ki;
    logic [15:0] r_key, n_key;     // search target of the direct scan
    logic [15:0] r_dkc, n_dkc;
    logic [1:0]  r_hex, n_hex;
    logic [1:0]  r_mode, n_mode;   // 0 codepoint, 1 base, 2 hex digit

    logic [DCW-1:0] w_dn;
    logic [KCW-1:0] w_kn;
    logic        w_dwr, w_kwr;
    logic [DAW-1:0] w_draddr;
    logic [KAW-1:0] w_kraddr;
    logic [3:0]  w_digit;

    // effective counts, saturated to depth
    always_comb begin
        if (XW'(i_direct_used) >= XW'(DIRECT_DEPTH)) w_dn = DCW'(DIRECT_DEPTH);
        else w_dn = DCW'(i_direct_used);
        if (XW'(i_dead_used) >= XW'(DEADKEY_DEPTH)) w_kn = KCW'(DEADKEY_DEPTH);
        else w_kn = KCW'(i_dead_used);
    end

    assign w_dwr = i_start && i_func == FUNC_DIRECT &&
                   {{DCW{1'b0}}, i_entry_index} < (DCW+8)'(DIRECT_DEPTH);
    assign w_kwr = i_start && i_func == FUNC_DEAD &&
                   {{KCW{1'b0}}, i_entry_index} < (KCW+8)'(DEADKEY_DEPTH);
    assign w_draddr = r_di[DAW-1:0];
    assign w_kraddr = r_ki[KAW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_dwr) r_dmem[DAW'(i_entry_index)] <= {i_entry_keycode, i_entry_codepoint};
        r_drd <= r_dmem[w_draddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_kwr) r_kmem[KAW'(i_entry_index)] <= {i_entry_base, i_entry_keycode, i_entry_codepoint};
        r_krd <= r_kmem[w_kraddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_IDLE;
            r_partial <= '0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_partial <= n_partial;
        end
        r_cp   <= n_cp;
        r_di   <= n_di;
        r_ki   <= n_ki;
        r_key  <= n_key;
        r_dkc  <= n_dkc;
        r_hex  <= n_hex;
        r_mode <= n_mode;
    end

    always_comb begin
        unique case (r_hex)
            2'd0:    w_digit = r_cp[15:12];
            2'd1:    w_digit = r_cp[11:8];
            2'd2:    w_digit = r_cp[7:4];
            default: w_digit = r_cp[3:0];
        endcase
    end

    always_comb begin
        logic        typ;
        logic [20:0] cp;
        n_state   = r_state;
        n_phase   = r_phase;
        n_partial = r_partial;
        n_cp      = r_cp;
        n_di      = r_di;
        n_ki      = r_ki;
        n_key     = r_key;
        n_dkc     = r_dkc;
        n_hex     = r_hex;
        n_mode    = r_mode;
        o_tap_req = '0;
        o_valid   = 1'b0;
        o_action  = ACT_PRESS;
        o_key     = KEY_LALT;
        o_last    = 1'b0;
        typ = 1'b0;
        cp  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start && i_func == FUNC_TEXT) begin
                    if (!i_text_byte[7]) begin
                        n_phase = PH_IDLE;
                        typ = 1'b1;
                        cp  = {13'd0, i_text_byte};
                    end else if (i_text_byte[7:6] == 2'b10) begin
                        n_partial = {r_partial[14:0], i_text_byte[5:0]};
                        unique case (r_phase)
                            PH_2OF3: n_phase = PH_3OF3;
                            PH_2OF4: n_phase = PH_3OF4;
                            PH_3OF4: n_phase = PH_4OF4;
                            PH_2OF2, PH_3OF3, PH_4OF4: begin
                                n_phase = PH_IDLE;
                                typ = 1'b1;
                                cp  = n_partial;
                            end
                            default: n_phase = PH_IDLE;
                        endcase
                    end else if (i_text_byte[7:5] == 3'b110) begin
                        n_partial = {16'd0, i_text_byte[4:0]};
                        n_phase   = PH_2OF2;
                    end else if (i_text_byte[7:4] == 4'b1110) begin
                        n_partial = {17'd0, i_text_byte[3:0]};
                        n_phase   = PH_2OF3;
                    end else if (i_text_byte[7:3] == 5'b11110) begin
                        n_partial = {18'd0, i_text_byte[2:0]};
                        n_phase   = PH_2OF4;
                    end
                    if (typ) begin
                        n_cp    = cp;
                        n_mode  = 2'd0;
                        n_di    = '0;
                        n_state = S_D_RD;
                    end
                end
            end
            S_D_RD: begin
                // target: codepoint (mode 0), base (mode 1) or hex char (mode 2)
                unique case (r_mode)
                    2'd0:    n_key = (r_cp[20:16] == 5'd0) ? r_cp[15:0] : 16'hFFFF;
                    2'd1:    n_key = r_krd[47:32];
                    default: n_key = {8'd0, hex_char(w_digit)};
                endcase
                if (r_mode == 2'd0 && r_cp[20:16] != 5'd0) begin
                    // codepoint above 16 bits never matches
                    n_di = w_dn;
                end
                n_state = S_D_CHK;
            end
            S_D_CHK: begin
                // r_drd holds entry r_di from previous cycle address
                if (r_di >= w_dn) begin
                    n_dkc = '0;
                    unique case (r_mode)
                        2'd0: begin
                            n_ki = '0;
                            n_state = S_K_RD;
                        end
                        2'd1: n_state = S_K_CHK;
                        default: n_state = S_H_TAP;
                    endcase
                end else if (r_drd[15:0] == r_key) begin
                    n_dkc = r_drd[31:16];
                    unique case (r_mode)
                        2'd0: n_state = (r_drd[31:16] != 16'd0) ? S_TAP_DIRECT : S_K_RD;
                        2'd1: n_state = S_K_CHK;
                        default: n_state = S_H_TAP;
                    endcase
                    if (r_mode == 2'd0) n_ki = '0;
                end else begin
                    n_di = r_di + 1'b1;
                    n_state = S_B_RD;
                end
            end
            S_B_RD: begin
                // wait state for the registered read of the next entry
                n_state = S_D_CHK;
            end
            S_K_RD: begin
                n_state = S_B_CHK;
            end
            S_B_CHK: begin
                if (r_ki >= w_kn) begin
                    n_hex   = 2'd0;
                    n_state = S_ALT_PRESS;
                end else if (r_krd[15:0] == r_cp[15:0] && r_cp[20:16] == 5'd0) begin
                    if (r_krd[47:32] == r_cp[15:0]) begin
                        n_dkc   = r_krd[31:16];
                        n_state = S_K_CHK;
                    end else begin
                        n_mode  = 2'd1;
                        n_di    = '0;
                        n_state = S_D_RD;
                    end
                end else begin
                    n_ki    = r_ki + 1'b1;
                    n_state = S_K_RD;
                end
            end
            S_K_CHK: begin
                // r_dkc holds the base keycode; r_krd still the dead entry
                if (r_dkc != 16'd0) begin
                    n_state = S_TAP_DEAD;
                end else begin
                    n_mode  = 2'd0;
                    n_ki    = r_ki + 1'b1;
                    n_state = S_K_RD;
                end
            end
            S_TAP_DEAD: begin
                o_tap_req.start     = 1'b1;
                o_tap_req.kc        = r_krd[31:16];
                o_tap_req.final_one = 1'b0;
                n_state = S_WAIT_DEAD;
            end
            S_WAIT_DEAD: if (!i_tap_stat.busy) n_state = S_TAP_BASE;
            S_TAP_BASE: begin
                o_tap_req.start     = 1'b1;
                o_tap_req.kc        = r_dkc;
                o_tap_req.final_one = 1'b1;
                n_state = S_WAIT_BASE;
            end
            S_WAIT_BASE: if (!i_tap_stat.busy) n_state = S_IDLE;
            S_TAP_DIRECT: begin
                o_tap_req.start     = 1'b1;
                o_tap_req.kc        = r_dkc;
                o_tap_req.final_one = 1'b1;
                n_state = S_WAIT_DIRECT;
            end
            S_WAIT_DIRECT: if (!i_tap_stat.busy) n_state = S_IDLE;
            S_ALT_PRESS: begin
                o_valid  = 1'b1;
                o_action = ACT_PRESS;
                if (i_ready) n_state = S_H_RD;
            end
            S_H_RD: begin
                n_mode  = 2'd2;
                n_di    = '0;
                n_state = S_D_RD;
            end
            S_H_TAP: begin
                o_tap_req.start     = 1'b1;
                o_tap_req.kc        = r_dkc | FLAG_ALT;
                o_tap_req.final_one = 1'b0;
                n_state = S_H_WAIT;
            end
            S_H_WAIT: begin
                if (!i_tap_stat.busy) begin
                    n_hex   = r_hex + 2'd1;
                    n_state = (r_hex == 2'd3) ? S_ALT_REL : S_H_RD;
                end
            end
            S_ALT_REL: begin
                o_valid  = 1'b1;
                o_action = ACT_RELEASE;
                o_last   = 1'b1;
                if (i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
endmodule

>>> design/utf8_to_hid_keystrokes_core.sv
// utf-8 bytes in, keyboard actions out. one input transfer is taken at a time;
// s_axis_tready stays low until every action of the byte has been sent.
// a codepoint is looked up by scanning the direct table entry by entry and then
// the dead key table, through the one registered read port of each table; a
// dead key entry whose base differs from the codepoint repeats the direct scan
// for the base, and hex fallback repeats it once per digit. actions leave one at
// a time through a single output register and wait while m_axis_tready is low.
// tables read only entries below the programmed entry counts, which must all
// have been written.
module utf8_to_hid_keystrokes_core #(
    parameter int DIRECT_DEPTH  = 256,
    parameter int DEADKEY_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] func
    input  logic [1:0]  s_axis_tuser,
    // [7:0] text_byte, [15:8] entry_index, [31:16] entry_codepoint,
    // [47:32] entry_keycode, [63:48] entry_base
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] action, [9:2] key, [15:10] zero
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import u2hk_pkg::*;

    logic [8:0] r_direct_used;
    logic [6:0] r_dead_used;
    logic       w_start, w_busy;
    t_tap_req   w_req;
    t_tap_stat  w_stat;
    logic       w_sv, w_tv, w_sl, w_tl;
    logic [1:0] w_sa, w_ta;
    logic [7:0] w_sk, w_tk;
    logic       r_ov;
    logic [1:0] r_oa;
    logic [7:0] r_ok;
    logic       r_ol;
    logic       w_ord;

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direct_used <= '0;
            r_dead_used   <= '0;
        end else if (psel && penable && pwrite) begin
            if (paddr == {REG_DIRECT_USED[0], 2'b00}) r_direct_used <= pwdata[8:0];
            if (paddr == {REG_DEAD_USED[0], 2'b00})   r_dead_used   <= pwdata[6:0];
        end
    end
    always_comb begin
        if (paddr == {REG_DIRECT_USED[0], 2'b00}) prdata = {23'd0, r_direct_used};
        else if (paddr == {REG_DEAD_USED[0], 2'b00}) prdata = {25'd0, r_dead_used};
        else prdata = '0;
    end

    // single output register, loaded only while it is empty; sources advance only then
    assign w_ord = !r_ov;
    assign s_axis_tready = !w_busy && !w_stat.busy && !r_ov;
    assign w_start = s_axis_tvalid && s_axis_tready;

    u2hk_seq #(.DIRECT_DEPTH(DIRECT_DEPTH), .DEADKEY_DEPTH(DEADKEY_DEPTH)) u_seq (
        .i_clk, .i_rst_n,
        .i_start(w_start),
        .i_func(s_axis_tuser),
        .i_text_byte(s_axis_tdata[7:0]),
        .i_entry_index(s_axis_tdata[15:8]),
        .i_entry_codepoint(s_axis_tdata[31:16]),
        .i_entry_keycode(s_axis_tdata[47:32]),
        .i_entry_base(s_axis_tdata[63:48]),
        .i_direct_used(r_direct_used),
        .i_dead_used(r_dead_used),
        .o_busy(w_busy),
        .o_tap_req(w_req),
        .i_tap_stat(w_stat),
        .o_valid(w_sv), .i_ready(w_ord),
        .o_action(w_sa), .o_key(w_sk), .o_last(w_sl)
    );

    u2hk_tap u_tap (
        .i_clk, .i_rst_n,
        .i_req(w_req), .o_stat(w_stat),
        .o_valid(w_tv), .i_ready(w_ord),
        .o_action(w_ta), .o_key(w_tk), .o_last(w_tl)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_ov) begin
            if (m_axis_tready) r_ov <= 1'b0;
        end else begin
            r_ov <= w_sv || w_tv;
        end
        if (!r_ov) begin
            if (w_tv) begin
                r_oa <= w_ta; r_ok <= w_tk; r_ol <= w_tl;
            end else begin
                r_oa <= w_sa; r_ok <= w_sk; r_ol <= w_sl;
            end
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {6'd0, r_ok, r_oa};
    assign m_axis_tlast  = r_ol;
endmodule

>>> design/u2hk_checker.sv
module u2hk_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    import u2hk_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output dropped while stalled");

    a_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
        else $error("bad action code");

    a_noin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while result pending");

    a_lastkey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[1:0] != ACT_PRESS)
        else $error("last on a press");
endmodule

bind utf8_to_hid_keystrokes_core u2hk_checker u_chk (
    .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
);

>>> sim/keystroke_checker.sv
`timescale 1ns / 1ps

module keystroke_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [1:0]  i_s_tuser,
    input  logic [63:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,
    input  logic        i_m_tlast,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_errors,
    output int          o_pending
);
    import u2hk_pkg::*;

    localparam int DIRECT_SLOTS = 256;
    localparam int DEAD_SLOTS   = 64;
    localparam logic [15:0] SHIFT_BIT = 16'h0100;
    localparam logic [15:0] ALTGR_BIT = 16'h0200;
    localparam logic [7:0]  CHAR_ZERO = 8'h30;
    localparam logic [7:0]  CHAR_LC_A = 8'h61;
    localparam logic [2:0]  ADDR_DIRECT = 3'(REG_DIRECT_USED * 4);
    localparam logic [2:0]  ADDR_DEAD   = 3'(REG_DEAD_USED * 4);

    typedef struct packed {
        logic [1:0] act;
        logic [7:0] key;
        logic       last;
    } t_key_action;

    t_key_action action_q[$];

    logic [15:0] dir_cp [DIRECT_SLOTS];
    logic [15:0] dir_kc [DIRECT_SLOTS];
    logic [15:0] dk_cp  [DEAD_SLOTS];
    logic [15:0] dk_kc  [DEAD_SLOTS];
    logic [15:0] dk_base[DEAD_SLOTS];
    logic [8:0]  n_direct;
    logic [6:0]  n_dead;
    t_phase      phase;
    logic [20:0] partial;
    int          errors;

    function automatic logic [15:0] direct_keycode(input logic [20:0] cp);
        int n;
        n = (n_direct > DIRECT_SLOTS) ? DIRECT_SLOTS : int'(n_direct);
        for (int i = 0; i < n; i++) begin
            if ({5'd0, dir_cp[i]} == cp) return dir_kc[i];
        end
        return 16'd0;
    endfunction

    task automatic push_action(input logic [1:0] a, input logic [7:0] k);
        action_q.push_back('{act: a, key: k, last: 1'b0});
    endtask

    task automatic tap_key(input logic [15:0] kc);
        if (kc & SHIFT_BIT) push_action(ACT_PRESS, KEY_LSHIFT);
        if (kc & ALTGR_BIT) push_action(ACT_PRESS, KEY_RALT);
        if (kc & FLAG_ALT)  push_action(ACT_PRESS, KEY_LALT);
        push_action(ACT_TAP, kc[7:0] + TAP_OFFSET);
        if (kc & SHIFT_BIT) push_action(ACT_RELEASE, KEY_LSHIFT);
        if (kc & ALTGR_BIT) push_action(ACT_RELEASE, KEY_RALT);
        if (kc & FLAG_ALT)  push_action(ACT_RELEASE, KEY_LALT);
    endtask

    task automatic type_codepoint(input logic [20:0] cp);
        logic [15:0] kc;
        logic [15:0] bkc;
        logic [3:0]  d;
        logic [7:0]  ch;
        int          n;
        kc = direct_keycode(cp);
        if (kc != 0) begin
            tap_key(kc);
            return;
        end
        n = (n_dead > DEAD_SLOTS) ? DEAD_SLOTS : int'(n_dead);
        for (int i = 0; i < n; i++) begin
            if ({5'd0, dk_cp[i]} == cp) begin
                bkc = ({5'd0, dk_base[i]} == cp) ? dk_kc[i] : direct_keycode({5'd0, dk_base[i]});
                if (bkc != 0) begin
                    tap_key(dk_kc[i]);
                    tap_key(bkc);
                    return;
                end
            end
        end
        // alt + four hex digits of the low 16 bits
        push_action(ACT_PRESS, KEY_LALT);
        for (int s = 3; s >= 0; s--) begin
            d  = cp[4*s +: 4];
            ch = (d < 4'd10) ? CHAR_ZERO + 8'(d) : CHAR_LC_A + 8'(d) - 8'd10;
            tap_key(direct_keycode({13'd0, ch}) | FLAG_ALT);
        end
        push_action(ACT_RELEASE, KEY_LALT);
    endtask

    task automatic decode_byte(input logic [7:0] c);
        if (!c[7]) begin
            phase = PH_IDLE;
            type_codepoint({13'd0, c});
        end else if (c[7:6] == 2'b10) begin
            partial = {partial[14:0], c[5:0]};
            case (phase)
                PH_2OF3: phase = PH_3OF3;
                PH_2OF4: phase = PH_3OF4;
                PH_3OF4: phase = PH_4OF4;
                PH_2OF2, PH_3OF3, PH_4OF4: begin
                    phase = PH_IDLE;
                    type_codepoint(partial);
                end
                default: phase = PH_IDLE;
            endcase
        end else if (c[7:5] == 3'b110) begin
            partial = {16'd0, c[4:0]};
            phase   = PH_2OF2;
        end else if (c[7:4] == 4'b1110) begin
            partial = {17'd0, c[3:0]};
            phase   = PH_2OF3;
        end else if (c[7:3] == 5'b11110) begin
            partial = {18'd0, c[2:0]};
            phase   = PH_2OF4;
        end
    endtask

    // t holds func in [1:0] and the data fields above it
    task automatic take_transfer(input logic [65:0] t);
        int first;
        first = action_q.size();
        case (t[1:0])
            FUNC_TEXT: decode_byte(t[9:2]);
            FUNC_DIRECT: begin
                dir_cp[t[17:10]] = t[33:18];
                dir_kc[t[17:10]] = t[49:34];
            end
            FUNC_DEAD: begin
                if (t[17:10] < DEAD_SLOTS) begin
                    dk_cp[t[17:10]]   = t[33:18];
                    dk_kc[t[17:10]]   = t[49:34];
                    dk_base[t[17:10]] = t[65:50];
                end
            end
            default: ;
        endcase
        if (action_q.size() > first) action_q[action_q.size() - 1].last = 1'b1;
    endtask

    task automatic check_action(input logic [15:0] t, input logic l);
        t_key_action want;
        if (action_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected action %0d key %02h last %0d, expected nothing",
                     $time, t[1:0], t[9:2], l);
        end else begin
            want = action_q.pop_front();
            if (want.act !== t[1:0] || want.key !== t[9:2] || want.last !== l) begin
                errors++;
                $display("%0t: expected action %0d key %02h last %0d, got %0d key %02h last %0d",
                         $time, want.act, want.key, want.last, t[1:0], t[9:2], l);
            end
        end
    endtask

    initial begin
        errors    = 0;
        o_errors  = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            action_q.delete();
            n_direct = '0;
            n_dead   = '0;
            phase    = PH_IDLE;
            partial  = '0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr == ADDR_DIRECT) n_direct = i_pwdata[8:0];
                else if (i_paddr == ADDR_DEAD) n_dead = i_pwdata[6:0];
            end
            if (i_s_tvalid && i_s_tready) take_transfer({i_s_tdata, i_s_tuser});
            if (i_m_tvalid && i_m_tready) check_action(i_m_tdata, i_m_tlast);
        end
        o_errors  <= errors;
        o_pending <= action_q.size();
    end

endmodule

>>> sim/utf8_to_hid_keystrokes_core_tb.sv
`timescale 1ns / 1ps

module utf8_to_hid_keystrokes_core_tb;
    import u2hk_pkg::*;

    localparam int CYCLE_LIMIT   = 4000000;
    localparam int DIRECT_LOADED = 40;
    localparam int DEAD_LOADED   = 10;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [1:0]  s_axis_tuser = '0;
    logic [63:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int          errors;
    int          pending;
    logic        no_gaps = 1'b0;
    logic [15:0] direct_cps[DIRECT_LOADED];
    logic [15:0] dead_cps[DEAD_LOADED];

    utf8_to_hid_keystrokes_core u_dut (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tuser, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    keystroke_checker u_checker (
        .i_clk, .i_rst_n,
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready),
        .i_s_tuser(s_axis_tuser), .i_s_tdata(s_axis_tdata),
        .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready),
        .i_m_tdata(m_axis_tdata), .i_m_tlast(m_axis_tlast),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .i_pready(pready),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int draw_gap();
        return no_gaps ? 0 : $urandom_range(0, 10);
    endfunction

    // func in the low two bits, the data fields above it
    function automatic logic [65:0] pack_item(input logic [1:0] f, input logic [7:0] b,
                                              input logic [7:0] idx, input logic [15:0] cp,
                                              input logic [15:0] kc, input logic [15:0] base);
        return {base, kc, cp, idx, b, f};
    endfunction

    task automatic send_item(input logic [65:0] d);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= d[1:0];
        s_axis_tdata  <= d[65:2];
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(pack_item(FUNC_TEXT, b, 8'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom)));
    endtask

    // encode one codepoint as utf-8, optionally cutting off the final byte
    task automatic send_codepoint(input logic [20:0] cp, input logic cut);
        logic [7:0] seq[4];
        int         len;
        if (cp < 21'h80) begin
            seq[0] = cp[7:0]; len = 1;
        end else if (cp < 21'h800) begin
            seq[0] = {3'b110, cp[10:6]}; seq[1] = {2'b10, cp[5:0]}; len = 2;
        end else if (cp < 21'h10000) begin
            seq[0] = {4'b1110, cp[15:12]}; seq[1] = {2'b10, cp[11:6]};
            seq[2] = {2'b10, cp[5:0]}; len = 3;
        end else begin
            seq[0] = {5'b11110, cp[20:18]}; seq[1] = {2'b10, cp[17:12]};
            seq[2] = {2'b10, cp[11:6]}; seq[3] = {2'b10, cp[5:0]}; len = 4;
        end
        if (cut && len > 1) len--;
        for (int i = 0; i < len; i++) send_byte(seq[i]);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || !s_axis_tready);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 3'(idx * 4);
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_counts(input logic [31:0] n_direct, input logic [31:0] n_dead);
        settle();
        reg_write(REG_DIRECT_USED, n_direct);
        reg_write(REG_DEAD_USED, n_dead);
    endtask

    // counts are never set above the slots loaded here
    task automatic load_tables();
        logic [15:0] cp;
        logic [15:0] kc;
        logic [15:0] base;
        int          r;
        for (int i = 0; i < DIRECT_LOADED; i++) begin
            if (i < 10)      cp = 16'h30 + 16'(i);
            else if (i < 16) cp = 16'h61 + 16'(i - 10);
            else if (i < 24) cp = 16'($urandom_range(16'h20, 16'h7e));
            else if (i < 30) cp = 16'($urandom_range(16'h80, 16'h7ff));
            else if (i < 36) cp = 16'($urandom_range(16'h800, 16'hffff));
            else             cp = 16'($urandom);
            kc = 16'($urandom);
            if (i % 17 == 5) kc = '0;
            direct_cps[i] = cp;
            send_item(pack_item(FUNC_DIRECT, 8'($urandom), 8'(i), cp, kc, 16'($urandom)));
        end
        for (int i = 0; i < DEAD_LOADED; i++) begin
            cp = (i % 4 == 3) ? 16'($urandom) : 16'($urandom_range(16'hc0, 16'h2ff));
            r  = $urandom_range(0, 2);
            base = (r == 0) ? cp : (r == 1) ? direct_cps[$urandom_range(16, DIRECT_LOADED - 1)]
                                             : 16'($urandom);
            dead_cps[i] = cp;
            send_item(pack_item(FUNC_DEAD, 8'($urandom), 8'(i), cp, 16'($urandom), base));
        end
        // slots past the dead key table and the unused function code
        repeat (3) send_item(pack_item(FUNC_DEAD, 8'($urandom), 8'($urandom_range(64, 255)),
                                       16'($urandom), 16'($urandom), 16'($urandom)));
        send_item(pack_item(2'd3, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom)));
    endtask

    task automatic random_text(input int n_cps);
        logic [20:0] cp;
        int          r;
        repeat (n_cps) begin
            r = $urandom_range(0, 99);
            case ($urandom_range(0, 4))
                0, 1: cp = {5'd0, direct_cps[$urandom_range(0, DIRECT_LOADED - 1)]};
                2:    cp = {5'd0, dead_cps[$urandom_range(0, DEAD_LOADED - 1)]};
                3:    cp = 21'($urandom_range(0, 127));
                default: cp = 21'($urandom);
            endcase
            if (r < 12) send_byte(8'($urandom));
            else send_codepoint(cp, r < 22);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty tables: every completed codepoint goes out as alt + hex
        send_byte(8'h00);
        send_byte(8'h7f);
        send_byte(8'h41);
        send_codepoint(21'h0a9, 1'b0);
        send_codepoint(21'h20ac, 1'b0);
        send_codepoint(21'h1f600, 1'b0);
        send_codepoint(21'h1fffff, 1'b0);
        send_byte(8'h80);                  // stray continuation
        send_byte(8'hf8);                  // invalid leads are ignored
        send_byte(8'hff);
        send_byte(8'he2);                  // ascii aborts a sequence
        send_byte(8'h5a);
        send_byte(8'hc3);
        send_byte(8'hc3);
        send_byte(8'ha9);
        send_item(pack_item(2'd3, 8'hff, 8'hff, 16'hffff, 16'hffff, 16'hffff));

        load_tables();
        set_counts(DIRECT_LOADED, DEAD_LOADED);
        random_text(12);
        no_gaps = 1'b1;
        random_text(8);
        no_gaps = 1'b0;
        set_counts($urandom_range(0, DIRECT_LOADED), $urandom_range(0, DEAD_LOADED));
        random_text(6);
        set_counts(16, 0);
        random_text(5);
        set_counts(0, 1);
        random_text(3);

        settle();
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // result side stalls, drawn per transfer
    initial begin
        forever begin
            int w;
            w = draw_gap();
            if (w > 0) begin
                m_axis_tready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> filelist.f
design/u2hk_pkg.sv
design/u2hk_tap.sv
design/u2hk_seq.sv
design/utf8_to_hid_keystrokes_core.sv
design/u2hk_checker.sv
sim/keystroke_checker.sv
sim/utf8_to_hid_keystrokes_core_tb.sv
